### hw/rtl/frdf_pkg.sv
`timescale 1ns / 1ps
// frdf_pkg: shared types and constants for the fat16 root directory file finder
// no dependencies; imported by every module of the block

package frdf_pkg;

    // directory entry layout
    localparam int unsigned ENTRY_BYTES = 32;
    localparam int unsigned OFS_W       = $clog2(ENTRY_BYTES);

    localparam logic [OFS_W-1:0] OFS_STATUS  = OFS_W'(0);
    localparam logic [OFS_W-1:0] OFS_ATTR    = OFS_W'(11);
    localparam logic [OFS_W-1:0] OFS_CLUS_LO = OFS_W'(26);
    localparam logic [OFS_W-1:0] OFS_CLUS_HI = OFS_W'(27);

    localparam logic [7:0] DELETED_MARK = 8'hE5;
    localparam logic [7:0] ATTR_MASK    = 8'h1F;
    localparam logic [7:0] END_MARK     = 8'h00;

    localparam int unsigned SECTOR_SHIFT = 9;
    localparam int unsigned ADDR_W       = 32;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FILE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_SHIFT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DATA_START = CFG_IDX_W'(2);

    localparam logic [7:0]  TARGET_FILE_RST   = 8'd1;
    localparam logic [2:0]  CLUSTER_SHIFT_RST = 3'd6;
    localparam logic [15:0] DATA_START_RST    = 16'd0;
    localparam logic [7:0]  FILES_SEEN_RST    = 8'd1;

    typedef struct packed {
        logic [7:0] dir_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] byte_address;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  target_file;
        logic [2:0]  cluster_shift;
        logic [15:0] data_start_sector;
    } cfg_t;

    // result of one parse step
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } parse_res_t;

endpackage

### hw/rtl/frdf_addr.sv
`timescale 1ns / 1ps
// frdf_addr: card byte address from start cluster and volume geometry
// depends on frdf_pkg

module frdf_addr
    import frdf_pkg::*;
(
    input  logic [15:0]       cluster,
    input  logic [2:0]        cluster_shift,
    input  logic [15:0]       data_start_sector,
    output logic [ADDR_W-1:0] byte_address
);

    logic [ADDR_W-1:0] rel_cluster;
    logic [ADDR_W-1:0] rel_sector;
    logic [ADDR_W-1:0] sector;

    always_comb begin
        // cluster numbering starts at two; below two wraps
        rel_cluster  = {16'd0, cluster} - ADDR_W'(2);
        rel_sector   = rel_cluster << cluster_shift;
        sector       = rel_sector + {16'd0, data_start_sector};
        byte_address = {sector[ADDR_W-SECTOR_SHIFT-1:0], SECTOR_SHIFT'(0)};
    end

endmodule

### hw/rtl/frdf_parser.sv
`timescale 1ns / 1ps
// frdf_parser: directory entry tracking, plain file count and result forming
// depends on frdf_pkg and frdf_addr

module frdf_parser
    import frdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  in_item_t   item,
    input  cfg_t       cfg,
    output parse_res_t res
);

    logic [OFS_W-1:0] offset_reg, offset_next;
    logic [7:0]       status_reg, status_next;
    logic [7:0]       attr_reg, attr_next;
    logic [7:0]       files_seen_reg, files_seen_next;
    logic [7:0]       cluster_low_reg, cluster_low_next;
    logic             done_reg, done_next;

    logic [OFS_W-1:0]  cur_offset;
    logic              active;
    logic              plain_file;
    logic [ADDR_W-1:0] file_address;

    frdf_addr u_addr (
        .cluster           ({item.dir_byte, cluster_low_reg}),
        .cluster_shift     (cfg.cluster_shift),
        .data_start_sector (cfg.data_start_sector),
        .byte_address      (file_address)
    );

    always_comb begin
        active     = item.first_byte || !done_reg;
        cur_offset = item.first_byte ? OFS_STATUS : offset_reg;
        plain_file = (status_reg != DELETED_MARK) && ((attr_reg & ATTR_MASK) == 8'd0);

        offset_next      = offset_reg;
        status_next      = status_reg;
        attr_next        = attr_reg;
        files_seen_next  = item.first_byte ? FILES_SEEN_RST : files_seen_reg;
        cluster_low_next = cluster_low_reg;
        done_next        = item.first_byte ? 1'b0 : done_reg;
        res              = '0;

        if (active) begin
            offset_next = cur_offset + OFS_W'(1);
            case (cur_offset)
                OFS_STATUS: begin
                    status_next = item.dir_byte;
                    if (item.dir_byte == END_MARK) begin
                        done_next = 1'b1;
                        res.valid = 1'b1;
                    end
                end
                OFS_ATTR: begin
                    attr_next = item.dir_byte;
                end
                OFS_CLUS_LO: begin
                    cluster_low_next = item.dir_byte;
                end
                OFS_CLUS_HI: begin
                    if (plain_file) begin
                        if (files_seen_next == cfg.target_file) begin
                            done_next              = 1'b1;
                            res.valid              = 1'b1;
                            res.item.found         = 1'b1;
                            res.item.byte_address  = file_address;
                        end else begin
                            files_seen_next = files_seen_next + 8'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg      <= '0;
            status_reg      <= '0;
            attr_reg        <= '0;
            files_seen_reg  <= FILES_SEEN_RST;
            cluster_low_reg <= '0;
            done_reg        <= 1'b1;
        end else if (step) begin
            offset_reg      <= offset_next;
            status_reg      <= status_next;
            attr_reg        <= attr_next;
            files_seen_reg  <= files_seen_next;
            cluster_low_reg <= cluster_low_next;
            done_reg        <= done_next;
        end
    end

endmodule

### hw/rtl/fat16_root_dir_file_finder.sv
`timescale 1ns / 1ps
// fat16_root_dir_file_finder: top level with input register, parser and result register
// depends on frdf_pkg, frdf_parser

// The block scans a FAT16 root directory streamed in one byte per transfer and
// reports the card byte address of the Nth plain file (not deleted, no
// attribute bits in 0x1F), N being target_file, counting from one. A transfer
// with first_byte set starts a new search at offset 0 of an entry; a zero first
// byte in an entry ends the search with found = 0 and address 0. After a result,
// bytes are dropped until the next first_byte. The result follows the byte at
// offset 27 of the matching entry. One byte is taken per clock while no result is
// stalled: each byte is parsed while it sits in the input register and its result
// is loaded into the output register at the next edge. A stalled result holds the
// parser; an empty input register still takes one more byte. Configuration writes
// are taken every cycle and must only happen idle.

module fat16_root_dir_file_finder
    import frdf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // directory byte stream
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    // search result
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    cfg_t      cfg_reg;

    // input register
    logic      in_valid_reg;
    in_item_t  in_data_reg;

    // result register
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic       proc_go;
    parse_res_t parse_res;

    // parse the held byte unless a waiting result would be overwritten
    assign proc_go   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_go;
    assign cfg_ready = 1'b1;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    frdf_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (proc_go),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .res     (parse_res)
    );

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_file       <= TARGET_FILE_RST;
            cfg_reg.cluster_shift     <= CLUSTER_SHIFT_RST;
            cfg_reg.data_start_sector <= DATA_START_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TARGET_FILE:   cfg_reg.target_file       <= cfg_data[7:0];
                REG_CLUSTER_SHIFT: cfg_reg.cluster_shift     <= cfg_data[2:0];
                REG_DATA_START:    cfg_reg.data_start_sector <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register: loads on every input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // result register: filled by a parse step that yields a result,
    // emptied by an output transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_go) begin
            out_valid_reg <= parse_res.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_go && parse_res.valid) begin
            out_data_reg <= parse_res.item;
        end
    end

endmodule

### hw/rtl/frdf_checker.sv
`timescale 1ns / 1ps
// frdf_checker: port-level assertions for the file finder, bound to the top level
// depends on frdf_pkg and fat16_root_dir_file_finder

module frdf_checker
    import frdf_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled result keeps its valid and payload
    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped or changed while stalled");

    // no result right out of reset
    property p_reset_quiet;
        @(posedge aclk) $past(!aresetn) |-> !m_valid;
    endproperty
    a_reset_quiet: assert property (p_reset_quiet) else $error("result valid after reset");

    // not-found results carry a zero address
    property p_not_found_zero;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.byte_address == '0;
    endproperty
    a_not_found_zero: assert property (p_not_found_zero) else $error("not-found result with address");

    // a new result traces back to an earlier input transfer or to a stalled input
    property p_result_needs_byte;
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2) || $past(!s_ready, 2);
    endproperty
    a_result_needs_byte: assert property (p_result_needs_byte)
        else $error("result without an input transfer");

endmodule

bind fat16_root_dir_file_finder frdf_checker u_frdf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
